// File: rtl/core/ihexld_pkg.sv
package ihexld_pkg;

	typedef struct packed {
		logic       kind;
		logic [7:0] char_code;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [15:0] write_address;
		logic [7:0]  write_byte;
		logic        in_protected;
		logic        last;
	} out_item_t;

	// One queued write: target address and data byte.
	typedef struct packed {
		logic [15:0] addr;
		logic [7:0]  data;
	} ring_entry_t;

	// Command from the parser to the output side.
	typedef struct packed {
		logic       is_write;
		logic [2:0] final_kind;
	} cmd_t;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [2:0] RK_DATA    = 3'd0;
	localparam logic [2:0] RK_EOF     = 3'd1;
	localparam logic [2:0] RK_CSUM    = 3'd2;
	localparam logic [2:0] RK_TIMEOUT = 3'd3;
	localparam logic [2:0] RK_LENGTH  = 3'd4;

	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF  = 8'h01;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] ALPHA_GAP = 8'd7;
	localparam logic [7:0] DIGIT_MAX = 8'd9;
	localparam logic [7:0] HEX_LO    = 8'd10;
	localparam logic [7:0] HEX_HI    = 8'd15;

	localparam logic [7:0] IDX_LENGTH  = 8'd0;
	localparam logic [7:0] IDX_ADDR_HI = 8'd1;
	localparam logic [7:0] IDX_ADDR_LO = 8'd2;
	localparam logic [7:0] IDX_TYPE    = 8'd3;
	localparam logic [7:0] IDX_DATA    = 8'd4;

	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_PROTECT = 1'b1;

	localparam logic [31:0] TIMEOUT_RESET = 32'd2000000;
	localparam logic [15:0] PROTECT_RESET = 16'd28672;

endpackage

// File: rtl/core/ihexld_ram.sv
module ihexld_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/ihexld_front.sv
module ihexld_front #(
	parameter int MAX_DATA_BYTES = 32,
	parameter int POS_W = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ihexld_pkg::in_item_t in_item,
	input  logic [31:0]          timeout_limit,
	input  logic                 q_full,
	output logic                 push,
	output ihexld_pkg::cmd_t     push_cmd,
	output logic [POS_W-1:0]     push_pos,
	output logic                 ram_we,
	output logic [POS_W-1:0]     ram_waddr,
	output ihexld_pkg::ring_entry_t ram_wdata
);

	import ihexld_pkg::*;

	localparam int RING = 2 * MAX_DATA_BYTES;
	localparam int CNT_W = $clog2(RING + 1);

	logic             halted_q;
	logic [7:0]       acc_q;
	logic [8:0]       nc_q;
	logic [7:0]       sum_q;
	logic [7:0]       len_q;
	logic [15:0]      addr_q;
	logic [7:0]       type_q;
	logic [31:0]      idle_q;
	logic [POS_W-1:0] head_q;
	logic [CNT_W-1:0] rdy_q;
	logic [CNT_W-1:0] pend_q;
	logic             fin_valid_q;
	logic [2:0]       fin_kind_q;

	logic             halted_d;
	logic [7:0]       acc_d;
	logic [8:0]       nc_d;
	logic [7:0]       sum_d;
	logic [7:0]       len_d;
	logic [15:0]      addr_d;
	logic [7:0]       type_d;
	logic [31:0]      idle_d;
	logic [POS_W-1:0] head_d;
	logic [CNT_W-1:0] rdy_d;
	logic [CNT_W-1:0] pend_d;
	logic             fin_valid_d;
	logic [2:0]       fin_kind_d;

	logic accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		logic [7:0]   c_off;
		logic [7:0]   c_alpha;
		logic         digit_ok;
		logic [3:0]   digit;
		logic [7:0]   idx;
		logic [7:0]   data_idx;
		logic         new_rec;
		logic         stop;
		logic [2:0]   stop_kind;
		logic [CNT_W:0] used;
		logic [CNT_W:0] slot;

		halted_d    = halted_q;
		acc_d       = acc_q;
		nc_d        = nc_q;
		sum_d       = sum_q;
		len_d       = len_q;
		addr_d      = addr_q;
		type_d      = type_q;
		idle_d      = idle_q;
		head_d      = head_q;
		rdy_d       = rdy_q;
		pend_d      = pend_q;
		fin_valid_d = fin_valid_q;
		fin_kind_d  = fin_kind_q;
		new_rec     = 1'b0;
		stop        = 1'b0;
		stop_kind   = RK_DATA;
		push        = 1'b0;
		push_cmd    = '0;
		push_pos    = head_q;
		ram_we      = 1'b0;

		// Decimal digits map directly; A to F sit seven codes above '9'+1.
		c_off    = in_item.char_code - CHAR_ZERO;
		c_alpha  = c_off - ALPHA_GAP;
		digit_ok = (c_off <= DIGIT_MAX) || (c_alpha >= HEX_LO && c_alpha <= HEX_HI);
		digit    = (c_off <= DIGIT_MAX) ? c_off[3:0] : c_alpha[3:0];

		idx      = 8'(nc_q + 9'd1 >> 1) - 8'd1;
		data_idx = idx - IDX_DATA;

		used = (CNT_W + 1)'(rdy_q) + (CNT_W + 1)'(pend_q);
		slot = (CNT_W + 1)'(head_q) + used;
		if (slot >= (CNT_W + 1)'(RING)) begin
			slot = slot - (CNT_W + 1)'(RING);
		end
		ram_waddr          = POS_W'(slot);
		ram_wdata.addr     = addr_q + 16'(data_idx);
		ram_wdata.data     = {acc_q[3:0], digit};

		if (accept && !halted_q) begin
			if (in_item.kind == KIND_CHAR) begin
				if (digit_ok) begin
					idle_d = '0;
					acc_d  = {acc_q[3:0], digit};
					nc_d   = nc_q + 9'd1;
					if (!nc_d[0]) begin
						sum_d = sum_q + acc_d;
						unique case (idx)
							IDX_LENGTH: begin
								len_d = acc_d;
								if (acc_d > 8'(MAX_DATA_BYTES)) begin
									stop      = 1'b1;
									stop_kind = RK_LENGTH;
								end
							end
							IDX_ADDR_HI: addr_d = {acc_d, 8'h00};
							IDX_ADDR_LO: addr_d = {addr_q[15:8], acc_d};
							IDX_TYPE:    type_d = acc_d;
							default: begin
								if (data_idx < len_q) begin
									if (used < (CNT_W + 1)'(RING)) begin
										ram_we = 1'b1;
										pend_d = pend_q + CNT_W'(1);
									end
								end else if (sum_d != 8'h00) begin
									stop      = 1'b1;
									stop_kind = RK_CSUM;
								end else if (type_q == REC_DATA) begin
									rdy_d   = rdy_q + pend_q;
									new_rec = 1'b1;
								end else if (type_q == REC_EOF) begin
									stop      = 1'b1;
									stop_kind = RK_EOF;
								end else begin
									new_rec = 1'b1;
								end
							end
						endcase
					end
				end else begin
					new_rec = 1'b1;
				end
			end else begin
				if (idle_q != '1) begin
					idle_d = idle_q + 32'd1;
				end
				if (idle_d >= timeout_limit) begin
					stop      = 1'b1;
					stop_kind = RK_TIMEOUT;
				end
			end
		end

		if (new_rec || stop) begin
			acc_d  = '0;
			nc_d   = '0;
			sum_d  = '0;
			pend_d = '0;
		end
		if (stop) begin
			halted_d    = 1'b1;
			fin_valid_d = 1'b1;
			fin_kind_d  = stop_kind;
		end

		// Each item releases at most one result: the oldest committed write,
		// otherwise the held final event once the parser has stopped.
		if (accept) begin
			if (rdy_d != '0) begin
				push              = 1'b1;
				push_cmd.is_write = 1'b1;
				push_pos          = head_q;
				head_d            = (head_q == POS_W'(RING - 1)) ? '0 : head_q + POS_W'(1);
				rdy_d             = rdy_d - CNT_W'(1);
			end else if (halted_d && fin_valid_d) begin
				push                = 1'b1;
				push_cmd.is_write   = 1'b0;
				push_cmd.final_kind = fin_kind_d;
				fin_valid_d         = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q    <= 1'b0;
			acc_q       <= '0;
			nc_q        <= '0;
			sum_q       <= '0;
			len_q       <= '0;
			addr_q      <= '0;
			type_q      <= '0;
			idle_q      <= '0;
			head_q      <= '0;
			rdy_q       <= '0;
			pend_q      <= '0;
			fin_valid_q <= 1'b0;
			fin_kind_q  <= '0;
		end else begin
			halted_q    <= halted_d;
			acc_q       <= acc_d;
			nc_q        <= nc_d;
			sum_q       <= sum_d;
			len_q       <= len_d;
			addr_q      <= addr_d;
			type_q      <= type_d;
			idle_q      <= idle_d;
			head_q      <= head_d;
			rdy_q       <= rdy_d;
			pend_q      <= pend_d;
			fin_valid_q <= fin_valid_d;
			fin_kind_q  <= fin_kind_d;
		end
	end

endmodule

// File: rtl/core/ihexld_cmd_q.sv
module ihexld_cmd_q #(
	parameter int DEPTH = 4,
	parameter int POS_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ihexld_pkg::cmd_t push_cmd,
	input  logic [POS_W-1:0] push_pos,
	input  logic             pop,
	output logic             full,
	output logic             valid,
	output ihexld_pkg::cmd_t head_cmd,
	output logic [POS_W-1:0] head_pos
);

	import ihexld_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             cmd_q [DEPTH];
	logic [POS_W-1:0] pos_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign valid    = (cnt_q != '0);
	assign head_cmd = cmd_q[rd_q];
	assign head_pos = pos_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			cmd_q[wr_q] <= push_cmd;
			pos_q[wr_q] <= push_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/core/ihexld_back.sv
module ihexld_back #(
	parameter int POS_W = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  ihexld_pkg::cmd_t        q_cmd,
	input  logic [POS_W-1:0]        q_pos,
	output logic                    q_pop,
	output logic                    ram_re,
	output logic [POS_W-1:0]        ram_raddr,
	input  ihexld_pkg::ring_entry_t ram_rdata,
	input  logic [15:0]             protect_start,
	output logic                    out_valid,
	input  logic                    out_ready,
	output ihexld_pkg::out_item_t   out_item
);

	import ihexld_pkg::*;

	logic      valid_s1;
	cmd_t      cmd_s1;
	logic      out_valid_q;
	out_item_t out_item_q;
	logic      advance;

	// The RAM read issued with the pop lands while the command sits in stage one.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign q_pop     = q_valid && (!valid_s1 || advance);
	assign ram_re    = q_pop && q_cmd.is_write;
	assign ram_raddr = q_pos;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1 <= q_cmd;
		end
		if (advance) begin
			out_item_q.last <= 1'b1;
			if (cmd_s1.is_write) begin
				out_item_q.result_kind   <= RK_DATA;
				out_item_q.write_address <= ram_rdata.addr;
				out_item_q.write_byte    <= ram_rdata.data;
				out_item_q.in_protected  <= (ram_rdata.addr >= protect_start);
			end else begin
				out_item_q.result_kind   <= cmd_s1.final_kind;
				out_item_q.write_address <= '0;
				out_item_q.write_byte    <= '0;
				out_item_q.in_protected  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/intel_hex_record_loader_core.sv
// Accepts one item per cycle while the command queue has room.
// A result passes through the command queue, the write-queue RAM read and the
// output register after the item that releases it.
// An item releases at most one result, so output throughput is one per item.
// Reset is asynchronous and active low; no clearing pass is needed.
module intel_hex_record_loader_core #(
	parameter int MAX_DATA_BYTES = 32,
	parameter int CMD_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ihexld_pkg::in_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ihexld_pkg::out_item_t out_item,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [31:0]           cfg_data
);

	import ihexld_pkg::*;

	localparam int RING = 2 * MAX_DATA_BYTES;
	localparam int POS_W = $clog2(RING);

	logic [31:0] timeout_limit_q;
	logic [15:0] protect_start_q;

	logic             q_full;
	logic             push;
	cmd_t             push_cmd;
	logic [POS_W-1:0] push_pos;
	logic             q_valid;
	logic             q_pop;
	cmd_t             q_cmd;
	logic [POS_W-1:0] q_pos;

	logic             ram_we;
	logic [POS_W-1:0] ram_waddr;
	ring_entry_t      ram_wdata;
	logic             ram_re;
	logic [POS_W-1:0] ram_raddr;
	ring_entry_t      ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_limit_q <= TIMEOUT_RESET;
			protect_start_q <= PROTECT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIMEOUT: timeout_limit_q <= cfg_data;
				CFG_PROTECT: protect_start_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	ihexld_front #(
		.MAX_DATA_BYTES(MAX_DATA_BYTES),
		.POS_W(POS_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.timeout_limit(timeout_limit_q),
		.q_full(q_full),
		.push(push),
		.push_cmd(push_cmd),
		.push_pos(push_pos),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata)
	);

	ihexld_cmd_q #(
		.DEPTH(CMD_DEPTH),
		.POS_W(POS_W)
	) u_cmd_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.push_pos(push_pos),
		.pop(q_pop),
		.full(q_full),
		.valid(q_valid),
		.head_cmd(q_cmd),
		.head_pos(q_pos)
	);

	ihexld_ram #(
		.WIDTH($bits(ring_entry_t)),
		.DEPTH(RING)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ihexld_back #(
		.POS_W(POS_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_cmd(q_cmd),
		.q_pos(q_pos),
		.q_pop(q_pop),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.protect_start(protect_start_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

endmodule

// File: rtl/core/ihexld_checker.sv
module ihexld_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input ihexld_pkg::out_item_t out_item
);

	import ihexld_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.result_kind <= RK_LENGTH && out_item.last)
		else $error("bad result kind or last flag");

	a_final_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.result_kind != RK_DATA |->
			out_item.write_address == 16'h0000 && out_item.write_byte == 8'h00 &&
			!out_item.in_protected)
		else $error("final event carries write fields");

	// A final event is the last result the block ever produces.
	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_item.result_kind != RK_DATA |=> !out_valid)
		else $error("result after final event");

endmodule

bind intel_hex_record_loader_core ihexld_checker u_ihexld_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item(out_item)
);

// File: dv/intel_hex_record_loader_core_tb.sv
module intel_hex_record_loader_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ihexld_pkg::*;

	localparam int REC_MAX = 32;
	localparam int RING = 2 * REC_MAX;
	localparam int HOLD_LEN = 400;
	localparam int PHASE_ITEMS = 60;
	localparam int DRAIN_ITEMS = 40;
	localparam logic [7:0] SEP_COLON = 8'h3A;
	localparam logic [7:0] REC_SEGMENT = 8'h02;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	// Stimulus and scoreboard.
	in_item_t char_stream[$];
	out_item_t due_results[$];
	int items_queued = 0;
	int items_taken = 0;
	int err_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_ask = 0;
	int hold_seen;
	int hold_left;
	longint gen_idle = 0;
	out_item_t want_item;

	// Register copies.
	logic [31:0] tb_timeout = TIMEOUT_RESET;
	logic [15:0] tb_protect = PROTECT_RESET;

	// Loader state as seen by the predictor.
	logic ld_halted = 1'b0;
	logic [7:0] acc_byte = '0;
	logic [8:0] nib_cnt = '0;
	logic [7:0] sum_acc = '0;
	logic [7:0] hdr_len = '0;
	logic [15:0] hdr_addr = '0;
	logic [7:0] hdr_type = '0;
	logic [31:0] idle_ticks = '0;
	logic [7:0] wq_data [RING];
	logic [15:0] wq_addr [RING];
	int wq_head = 0;
	int wq_ready = 0;
	int wq_pending = 0;
	logic final_held = 1'b0;
	logic [2:0] final_code = RK_DATA;

	intel_hex_record_loader_core #(.MAX_DATA_BYTES(REC_MAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Returns {valid, nibble}; only 0-9 and upper case A-F are digits.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		d = c - CHAR_ZERO;
		if (d > DIGIT_MAX) begin
			d = d - ALPHA_GAP;
			if (d < HEX_LO || d > HEX_HI)
				return 5'b0;
		end
		return {1'b1, d[3:0]};
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n > DIGIT_MAX)
			return CHAR_ZERO + ALPHA_GAP + 8'(n);
		return CHAR_ZERO + 8'(n);
	endfunction

	function automatic logic [7:0] noise_char();
		logic [7:0] c;
		logic [4:0] h;
		do begin
			c = 8'($urandom_range(0, 255));
			h = hex_digit(c);
		end while (h[4]);
		return c;
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 6);
		if (r < 90)
			return $urandom_range(0, REC_MAX);
		return REC_MAX;
	endfunction

	function automatic logic [15:0] pick_addr();
		int r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return 16'hFFF0 + 16'($urandom_range(0, 15));
		if (r == 1)
			return tb_protect + 16'($urandom_range(0, 8)) - 16'd4;
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic restart_record();
		acc_byte = '0;
		nib_cnt = '0;
		sum_acc = '0;
		wq_pending = 0;
	endtask

	task automatic halt_load(input logic [2:0] code);
		restart_record();
		ld_halted = 1'b1;
		final_held = 1'b1;
		final_code = code;
	endtask

	// Parses one accepted item, then releases at most one result.
	task automatic loader_step(input in_item_t it);
		logic [4:0] hx;
		int idx;
		int pos;
		out_item_t r;
		if (!ld_halted) begin
			if (it.kind == KIND_CHAR) begin
				hx = hex_digit(it.char_code);
				if (!hx[4]) begin
					restart_record();
				end else begin
					idle_ticks = '0;
					acc_byte = {acc_byte[3:0], hx[3:0]};
					nib_cnt = nib_cnt + 9'd1;
					if (!nib_cnt[0]) begin
						idx = int'(nib_cnt >> 1) - 1;
						sum_acc = sum_acc + acc_byte;
						if (idx == int'(IDX_LENGTH)) begin
							hdr_len = acc_byte;
							if (int'(hdr_len) > REC_MAX)
								halt_load(RK_LENGTH);
						end else if (idx == int'(IDX_ADDR_HI)) begin
							hdr_addr = {acc_byte, 8'h00};
						end else if (idx == int'(IDX_ADDR_LO)) begin
							hdr_addr[7:0] = acc_byte;
						end else if (idx == int'(IDX_TYPE)) begin
							hdr_type = acc_byte;
						end else if (idx - int'(IDX_DATA) < int'(hdr_len)) begin
							if (wq_ready + wq_pending < RING) begin
								pos = (wq_head + wq_ready + wq_pending) % RING;
								wq_data[pos] = acc_byte;
								wq_addr[pos] = hdr_addr + 16'(idx - int'(IDX_DATA));
								wq_pending++;
							end
						end else begin
							// Checksum byte: the record is complete.
							if (sum_acc != 8'h00) begin
								halt_load(RK_CSUM);
							end else if (hdr_type == REC_DATA) begin
								wq_ready += wq_pending;
								restart_record();
							end else if (hdr_type == REC_EOF) begin
								halt_load(RK_EOF);
							end else begin
								restart_record();
							end
						end
					end
				end
			end else begin
				if (idle_ticks != '1)
					idle_ticks = idle_ticks + 32'd1;
				if (idle_ticks >= tb_timeout)
					halt_load(RK_TIMEOUT);
			end
		end
		if (wq_ready > 0) begin
			r.result_kind = RK_DATA;
			r.write_address = wq_addr[wq_head];
			r.write_byte = wq_data[wq_head];
			r.in_protected = wq_addr[wq_head] >= tb_protect;
			r.last = 1'b1;
			due_results.push_back(r);
			wq_head = (wq_head + 1) % RING;
			wq_ready--;
		end else if (ld_halted && final_held) begin
			r = '0;
			r.result_kind = final_code;
			r.last = 1'b1;
			due_results.push_back(r);
			final_held = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		err_count++;
	endtask

	task automatic push_char(input logic [7:0] c);
		in_item_t it;
		logic [4:0] hx;
		it.kind = KIND_CHAR;
		it.char_code = c;
		char_stream.push_back(it);
		items_queued++;
		hx = hex_digit(c);
		if (hx[4])
			gen_idle = 0;
	endtask

	// Ticks are only queued while they keep clear of the timeout, unless forced.
	task automatic push_tick(input bit forced);
		in_item_t it;
		if (forced || gen_idle + 1 < longint'(tb_timeout)) begin
			it.kind = KIND_TICK;
			it.char_code = 8'($urandom_range(0, 255));
			char_stream.push_back(it);
			items_queued++;
			gen_idle++;
		end
	endtask

	task automatic queue_fillers(input int n);
		repeat (n) push_char(noise_char());
	endtask

	// Queues a separator and the first keep nibbles of a record with random data.
	task automatic queue_record(input logic [7:0] sep, input int len, input logic [15:0] addr,
			input logic [7:0] rtype, input logic [7:0] sum_err, input int keep);
		logic [7:0] rec[$];
		logic [7:0] sum;
		int nib;
		rec.push_back(8'(len));
		rec.push_back(addr[15:8]);
		rec.push_back(addr[7:0]);
		rec.push_back(rtype);
		repeat (len) rec.push_back(8'($urandom_range(0, 255)));
		sum = '0;
		foreach (rec[i])
			sum = sum + rec[i];
		rec.push_back(8'(-sum) + sum_err);
		push_char(sep);
		nib = 0;
		foreach (rec[i]) begin
			for (int h = 1; h >= 0; h--) begin
				if (nib < keep) begin
					push_char(hex_char(h ? rec[i][7:4] : rec[i][3:0]));
					if ($urandom_range(0, 99) < 3)
						push_tick(1'b0);
				end
				nib++;
			end
		end
	endtask

	// Mostly good data records; the rest are other types, cut records, noise and ticks.
	task automatic queue_random_phase(input int n);
		int target;
		int r;
		int len;
		logic [7:0] sep;
		target = items_queued + n;
		while (items_queued < target) begin
			r = $urandom_range(0, 99);
			sep = ($urandom_range(0, 4) != 0) ? SEP_COLON : noise_char();
			len = pick_len();
			if (r < 60) begin
				queue_record(sep, len, pick_addr(), REC_DATA, 8'h00, 1000);
			end else if (r < 70) begin
				queue_record(sep, len, pick_addr(), 8'($urandom_range(2, 255)), 8'h00, 1000);
			end else if (r < 80) begin
				queue_record(sep, len, pick_addr(), REC_DATA, 8'h00,
					$urandom_range(1, 2 * (len + 5) - 1));
			end else if (r < 90) begin
				repeat ($urandom_range(1, 4)) push_char(noise_char());
			end else begin
				repeat ($urandom_range(1, 3)) push_tick(1'b0);
			end
		end
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_TIMEOUT)
			tb_timeout = val;
		else
			tb_protect = val[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (items_taken != items_queued || due_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Sender: a new item is offered only once the previous one has been taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (char_stream.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				in_item <= char_stream.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver, with a long hold-off whenever one is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seen != hold_ask) begin
			hold_seen <= hold_ask;
			hold_left <= HOLD_LEN;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(0, 99) >= rx_idle_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				loader_step(in_item);
				items_taken++;
			end
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					report_mismatch("result with nothing expected", out_item.write_address, '0);
				end else begin
					want_item = due_results.pop_front();
					if (out_item.result_kind !== want_item.result_kind)
						report_mismatch("result_kind", 16'(out_item.result_kind),
							16'(want_item.result_kind));
					if (out_item.write_address !== want_item.write_address)
						report_mismatch("write_address", out_item.write_address,
							want_item.write_address);
					if (out_item.write_byte !== want_item.write_byte)
						report_mismatch("write_byte", 16'(out_item.write_byte),
							16'(want_item.write_byte));
					if (out_item.in_protected !== want_item.in_protected)
						report_mismatch("in_protected", 16'(out_item.in_protected),
							16'(want_item.in_protected));
					if (out_item.last !== want_item.last)
						report_mismatch("last", 16'(out_item.last), 16'(want_item.last));
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic [31:0] tmo;
		logic [15:0] prot;
		logic [2:0] fin;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: address wrap, an ignored record type, a cut record, odd characters.
		@(negedge clk);
		tx_idle_pct = 20;
		rx_idle_pct = 75;
		queue_record(8'h40, 2, 16'hFFFF, REC_DATA, 8'h00, 1000);
		queue_record(8'h47, 0, 16'h0000, REC_SEGMENT, 8'h00, 1000);
		// Lower case a is not a digit, so it restarts the record.
		queue_record(8'h61, 3, 16'h1234, REC_DATA, 8'h00, 3);
		push_char(8'hFF);
		push_tick(1'b0);
		push_char(8'h00);
		push_char(8'h2F);
		queue_fillers(DRAIN_ITEMS);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			tx_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 75 : 0;
			rx_idle_pct = (ph < 2) ? 75 : (ph < 4) ? 20 : 0;
			case (ph)
				0: begin tmo = '1; prot = 16'h0000; end
				1: begin tmo = $urandom_range(2, 40); prot = 16'hFFFF; end
				2: begin tmo = 32'd1; prot = 16'($urandom_range(0, 65535)); end
				3: begin tmo = ($urandom() | 32'd1); prot = PROTECT_RESET; end
				4: begin tmo = TIMEOUT_RESET; prot = 16'($urandom_range(0, 65535)); end
				default: begin tmo = $urandom_range(2, 40); prot = 16'hFFFF; end
			endcase
			write_reg(CFG_TIMEOUT, tmo);
			write_reg(CFG_PROTECT, {16'h0000, prot});
			@(negedge clk);
			queue_random_phase(PHASE_ITEMS);
			queue_fillers(DRAIN_ITEMS);
			// Stall the receiver while the sender keeps offering items.
			if (ph == 4)
				hold_ask = hold_ask + 1;
			wait_drained();
		end

		// The load ends once: pick how, right behind a good record so writes are queued.
		fin = 3'($urandom_range(RK_EOF, RK_LENGTH));
		write_reg(CFG_TIMEOUT, (fin == RK_TIMEOUT) ? 32'($urandom_range(1, 8)) : TIMEOUT_RESET);
		write_reg(CFG_PROTECT, 32'($urandom_range(0, 65535)));
		@(negedge clk);
		queue_random_phase(30);
		queue_record(SEP_COLON, $urandom_range(1, REC_MAX), pick_addr(), REC_DATA, 8'h00, 1000);
		case (fin)
			RK_EOF: queue_record(SEP_COLON, $urandom_range(0, 4), pick_addr(), REC_EOF,
				8'h00, 1000);
			RK_CSUM: queue_record(SEP_COLON, pick_len(), pick_addr(), REC_DATA,
				8'($urandom_range(1, 255)), 1000);
			RK_TIMEOUT: repeat (10) push_tick(1'b1);
			default: queue_record(SEP_COLON, $urandom_range(REC_MAX + 1, 255), pick_addr(),
				REC_DATA, 8'h00, 2 + $urandom_range(0, 6));
		endcase
		queue_fillers(DRAIN_ITEMS);
		// Everything after the halt is ignored, hex digits and ticks alike.
		repeat (10) push_char(8'($urandom_range(0, 255)));
		push_tick(1'b1);
		wait_drained();
		repeat (20) @(negedge clk);

		if (err_count == 0 && due_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: files.f
rtl/core/ihexld_pkg.sv
rtl/core/ihexld_ram.sv
rtl/core/ihexld_front.sv
rtl/core/ihexld_cmd_q.sv
rtl/core/ihexld_back.sv
rtl/core/intel_hex_record_loader_core.sv
rtl/core/ihexld_checker.sv
dv/intel_hex_record_loader_core_tb.sv
